@@ hw/rtl/lx_pkg.sv @@
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared result types, character codes and the per-byte lexing functions.
// ----------------------------------------------------------------------------
package lx_pkg;

    localparam int LX_MAX_ITEMS   = 6;
    localparam int LX_CNT_W       = $clog2(LX_MAX_ITEMS + 1);
    localparam int LX_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_WEND = 2'd1,
        K_OP   = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_PIPE   = 3'd0,
        OP_GT     = 3'd1,
        OP_LT     = 3'd2,
        OP_APPEND = 3'd3,
        OP_ERR    = 3'd4
    } t_op;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] word_byte;
        t_op        op;
    } t_item;

    // All results caused by one input word, in order
    typedef struct packed {
        t_item [LX_MAX_ITEMS-1:0] items;
        logic  [LX_CNT_W-1:0]     count;
    } t_bundle;

    typedef struct packed {
        logic       in_quote;
        logic       quote_dbl;
        logic [7:0] held_char;
        logic       held_valid;
        logic       word_open;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        t_bundle    bd;
    } t_work;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic lx_is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_work lx_emit(t_work w, t_kind k, logic [7:0] b, t_op op);
        t_work r;
        r = w;
        if (r.bd.count < LX_CNT_W'(LX_MAX_ITEMS)) begin
            r.bd.items[r.bd.count[$clog2(LX_MAX_ITEMS)-1:0]] = '{kind: k, word_byte: b, op: op};
            r.bd.count = r.bd.count + 1'b1;
        end
        return r;
    endfunction

    function automatic t_work lx_close(t_work w);
        t_work r;
        r = w;
        if (r.st.word_open) begin
            r = lx_emit(r, K_WEND, 8'h00, OP_PIPE);
            r.st.word_open = 1'b0;
        end
        return r;
    endfunction

    function automatic t_work lx_handle(t_work w, logic [7:0] c, logic may_hold);
        t_work r;
        r = w;
        if (r.st.in_quote) begin
            if (c == (r.st.quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
                r.st.in_quote = 1'b0;
                r = lx_close(r);
            end else begin
                r = lx_emit(r, K_BYTE, c, OP_PIPE);
                r.st.word_open = 1'b1;
            end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r = lx_close(r);
            r.st.in_quote  = 1'b1;
            r.st.quote_dbl = (c == CH_DQUOTE);
        end else if (lx_is_space(c)) begin
            r = lx_close(r);
        end else if (may_hold && (c == CH_GT || c == CH_TWO)) begin
            r.st.held_char  = c;
            r.st.held_valid = 1'b1;
        end else if (c == CH_PIPE) begin
            r = lx_close(r);
            r = lx_emit(r, K_OP, 8'h00, OP_PIPE);
        end else if (c == CH_GT) begin
            r = lx_close(r);
            r = lx_emit(r, K_OP, 8'h00, OP_GT);
        end else if (c == CH_LT) begin
            r = lx_close(r);
            r = lx_emit(r, K_OP, 8'h00, OP_LT);
        end else begin
            r = lx_emit(r, K_BYTE, c, OP_PIPE);
            r.st.word_open = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lx_front.sv @@
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts input words, runs the lexer state and builds the result bundle.
// ----------------------------------------------------------------------------
module lx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_line_end,
    input  lx_pkg::t_q_status i_q_status,
    output lx_pkg::t_q_push   o_q_push
);
    import lx_pkg::*;

    t_lex_state r_st;
    t_lex_state n_st;
    t_work      w;
    logic       accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        w.st = r_st;
        w.bd = '0;
        if (r_st.held_valid) begin
            w.st.held_valid = 1'b0;
            w.st.held_char  = 8'h00;
            if ((r_st.held_char == CH_GT || r_st.held_char == CH_TWO) && i_byte == CH_GT) begin
                w = lx_close(w);
                w = lx_emit(w, K_OP, 8'h00, (r_st.held_char == CH_GT) ? OP_APPEND : OP_ERR);
            end else begin
                w = lx_handle(w, r_st.held_char, 1'b0);
                w = lx_handle(w, i_byte, !i_line_end);
            end
        end else begin
            w = lx_handle(w, i_byte, !i_line_end);
        end
        if (i_line_end) begin
            w    = lx_close(w);
            w    = lx_emit(w, K_DONE, 8'h00, OP_PIPE);
            w.st = '0;
        end
        n_st = accept ? w.st : r_st;
    end

    // drop words that produce nothing
    assign o_q_push.valid  = accept && (w.bd.count != '0);
    assign o_q_push.bundle = w.bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

@@ hw/rtl/lx_queue.sv @@
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Short FIFO of result bundles between front end and serialiser.
// ----------------------------------------------------------------------------
module lx_queue #(
    parameter int DEPTH = lx_pkg::LX_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lx_pkg::t_q_push   i_push,
    input  logic              i_pop,
    output lx_pkg::t_bundle   o_head,
    output lx_pkg::t_q_status o_status
);
    import lx_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rd];

    assign do_push = i_push.valid && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/lx_back.sv @@
// ----------------------------------------------------------------------------
// Tokenizer back end
// Serialises the head bundle into one result word per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module lx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lx_pkg::t_bundle   i_head,
    input  lx_pkg::t_q_status i_q_status,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output lx_pkg::t_item     o_item,
    output logic              o_last
);
    import lx_pkg::*;

    localparam int IW = $clog2(LX_MAX_ITEMS);

    logic          r_valid;
    t_item         r_item;
    logic          r_last;
    logic [IW-1:0] r_idx;
    logic          n_valid;
    logic [IW-1:0] n_idx;
    logic          load;
    logic          at_end;

    assign load   = (!r_valid || i_ready) && !i_q_status.empty;
    assign at_end = (LX_CNT_W'(r_idx) == i_head.count - 1'b1);
    assign o_pop  = load && at_end;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_end ? '0 : r_idx + 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // payload register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_head.items[r_idx];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_last  = r_last;

endmodule

@@ hw/rtl/shell_command_line_tokenizer_top.sv @@
// Path: results are registered in the bundle queue and then in the serialiser's output register.
// Throughput: one input word per cycle while the bundle queue has room; results
// leave at one word per cycle while the sink is ready, one word per result.
// The output serialiser sets the sustained rate; the queue absorbs bursts.
// Reset: synchronous active low; clears lexer state, queue pointers and output valid.
// ----------------------------------------------------------------------------
// Command line tokenizer top level
// Splits a byte stream into word bytes, word ends, operators and line done.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_top #(
    parameter int QUEUE_DEPTH = lx_pkg::LX_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic        i_s_axis_tlast,   // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] word_byte, [10:8] operator_code, rest 0
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last
);
    import lx_pkg::*;

    t_q_push   q_push;
    t_q_status q_stat;
    t_bundle   q_head;
    logic      q_pop;
    t_item     out_item;

    lx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_line_end (i_s_axis_tlast),
        .i_q_status (q_stat),
        .o_q_push   (q_push)
    );

    lx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_stat)
    );

    lx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_stat),
        .o_pop      (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_item     (out_item),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, out_item.op, out_item.word_byte};
    assign o_m_axis_tuser = out_item.kind;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> !q_stat.full)
        else $error("bundle pushed into a full queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == K_DONE) |-> o_m_axis_tlast)
        else $error("line done word not marked last");

    a_byte_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != K_BYTE) |-> (o_m_axis_tdata[7:0] == 8'h00))
        else $error("non-byte word carries a character");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

endmodule

@@ sim/lx_token_checker.sv @@
// ----------------------------------------------------------------------------
// Command line tokenizer checker
// Watches both stream channels and keeps its own lexer state. Each accepted
// input byte is turned into the result words it should cause. Each accepted
// result word is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lx_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] byte_in
    input  logic        i_in_last,    // line_end
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,   // [7:0] word_byte, [10:8] operator_code, rest 0
    input  logic [1:0]  i_out_user,   // [1:0] kind
    input  logic        i_out_last,   // last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import lx_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] wbyte;
        t_op        op;
        logic       last;
    } t_token;

    t_token     expected_tokens[$];
    t_token     step_tokens[$];

    logic       lx_in_quote;
    logic       lx_quote_dbl;
    logic [7:0] lx_held_char;
    logic       lx_held_valid;
    logic       lx_word_open;

    int         fail_count = 0;
    int         checked    = 0;

    task automatic clear_lexer();
        lx_in_quote   = 1'b0;
        lx_quote_dbl  = 1'b0;
        lx_held_char  = 8'h00;
        lx_held_valid = 1'b0;
        lx_word_open  = 1'b0;
    endtask

    task automatic add_token(t_kind k, logic [7:0] b, t_op op);
        t_token t;
        t.kind  = k;
        t.wbyte = b;
        t.op    = op;
        t.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endtask

    task automatic end_word();
        if (lx_word_open) begin
            add_token(K_WEND, 8'h00, OP_PIPE);
            lx_word_open = 1'b0;
        end
    endtask

    task automatic lex_char(logic [7:0] c, bit may_hold);
        if (lx_in_quote) begin
            if (c == (lx_quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
                lx_in_quote = 1'b0;
                end_word();
            end else begin
                add_token(K_BYTE, c, OP_PIPE);
                lx_word_open = 1'b1;
            end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            end_word();
            lx_in_quote  = 1'b1;
            lx_quote_dbl = (c == CH_DQUOTE);
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            end_word();
        end else if (may_hold && (c == CH_GT || c == CH_TWO)) begin
            // hold for one byte: it may start a two-character operator
            lx_held_char  = c;
            lx_held_valid = 1'b1;
        end else if (c == CH_PIPE) begin
            end_word();
            add_token(K_OP, 8'h00, OP_PIPE);
        end else if (c == CH_GT) begin
            end_word();
            add_token(K_OP, 8'h00, OP_GT);
        end else if (c == CH_LT) begin
            end_word();
            add_token(K_OP, 8'h00, OP_LT);
        end else begin
            add_token(K_BYTE, c, OP_PIPE);
            lx_word_open = 1'b1;
        end
    endtask

    task automatic predict_tokens(logic [7:0] c, bit eol);
        logic [7:0] h;
        step_tokens.delete();
        if (lx_held_valid) begin
            h             = lx_held_char;
            lx_held_valid = 1'b0;
            lx_held_char  = 8'h00;
            if ((h == CH_GT || h == CH_TWO) && c == CH_GT) begin
                end_word();
                add_token(K_OP, 8'h00, (h == CH_GT) ? OP_APPEND : OP_ERR);
            end else begin
                lex_char(h, 1'b0);
                lex_char(c, !eol);
            end
        end else begin
            lex_char(c, !eol);
        end
        if (eol) begin
            end_word();
            add_token(K_DONE, 8'h00, OP_PIPE);
            clear_lexer();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endtask

    task automatic note_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_token t;
        if (!i_rst_n) begin
            clear_lexer();
            expected_tokens.delete();
        end else begin
            // check the result word first: it cannot stem from this edge's input
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    note_mismatch($sformatf("unexpected word kind %0d byte %02h op %0d last %0b",
                        i_out_user, i_out_data[7:0], i_out_data[10:8], i_out_last));
                end else begin
                    t = expected_tokens.pop_front();
                    if (i_out_user != t.kind || i_out_data[7:0] != t.wbyte ||
                        i_out_data[10:8] != t.op || i_out_last != t.last)
                        note_mismatch({
                            $sformatf("word %0d expected kind %0d byte %02h op %0d last %0b,",
                                checked, t.kind, t.wbyte, t.op, t.last),
                            $sformatf(" got kind %0d byte %02h op %0d last %0b",
                                i_out_user, i_out_data[7:0], i_out_data[10:8], i_out_last)});
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                predict_tokens(i_in_data, i_in_last);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_tokens.size();
        o_checked    <= checked;
    end

endmodule

@@ sim/shell_command_line_tokenizer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Feeds directed and random command lines byte by byte with random gaps on
// both channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_top_tb;
    import lx_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] byte_in
    logic        s_tlast   = 1'b0;    // line_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [7:0] word_byte, [10:8] operator_code, rest 0
    logic [1:0]  m_tuser;             // [1:0] kind
    logic        m_tlast;             // last

    int          fail_count;
    int          pending;
    int          checked;
    int          bytes_sent = 0;
    int          lines_sent = 0;
    bit          steady     = 1'b0;

    shell_command_line_tokenizer_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    lx_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .i_out_last   (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d result words outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(logic [7:0] c, bit eol);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (eol)
            lines_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Weighted towards the characters the lexer treats specially
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 36)
            return CH_SPACE;
        else if (r < 40)
            return CH_TAB + 8'($urandom_range(0, 4));
        else if (r < 44)
            return CH_SQUOTE;
        else if (r < 48)
            return CH_DQUOTE;
        else if (r < 57)
            return CH_GT;
        else if (r < 64)
            return CH_TWO;
        else if (r < 69)
            return CH_PIPE;
        else if (r < 74)
            return CH_LT;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stall before each word, then wait for it
    initial begin
        int gap;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // append, pipe and plain words
        send_text("ab>>c|");
        // held two and held greater that do not pair, tab, less at line end
        send_text("2x>\t<");
        // other quote kind inside a run, unterminated double quote
        send_text("'a\"b' \"c");
        // odd bytes as word characters, vertical tab, greater at line end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(CH_GT, 1'b1);
        // lone two at line end is a word byte
        send_byte(CH_TWO, 1'b1);

        while (bytes_sent < 220) begin
            steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_byte(pick_char(), i == len - 1);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d command lines with random gaps on both channels",
                 bytes_sent, lines_sent);
        $display("Checked %0d result words, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/lx_pkg.sv
hw/rtl/lx_front.sv
hw/rtl/lx_queue.sv
hw/rtl/lx_back.sv
hw/rtl/shell_command_line_tokenizer_top.sv
sim/lx_token_checker.sv
sim/shell_command_line_tokenizer_top_tb.sv
